@@ src/segment_display_scan_blink_unit_macros.svh @@
// Assertion helpers for the display scan block.
// Each macro takes a label, clock, active-low reset, two expressions and a message.
`ifndef SEGMENT_DISPLAY_SCAN_BLINK_UNIT_MACROS_SVH
`define SEGMENT_DISPLAY_SCAN_BLINK_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define SDSB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define SDSB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SDSB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SDSB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ src/sdsb_pkg.sv @@
`default_nettype none

package sdsb_pkg;

    localparam int DATA_W    = 32;
    localparam int MODE_W    = 3;
    localparam int SEL_W     = 4;
    localparam int CNT_W     = 4;
    localparam int POS_W     = 3;
    localparam int VIS_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_DIGITS_DEF  = 8;
    localparam int COUNT_RESET_DEF = 8;
    localparam logic [DATA_W-1:0] SCAN_PERIOD_RESET = DATA_W'(2);

    // item opcodes
    localparam logic [MODE_W-1:0] OP_TICK    = 3'd0;
    localparam logic [MODE_W-1:0] OP_PATTERN = 3'd1;
    localparam logic [MODE_W-1:0] OP_HIDE    = 3'd2;
    localparam logic [MODE_W-1:0] OP_SHOW    = 3'd3;
    localparam logic [MODE_W-1:0] OP_BLINK   = 3'd4;

    // digit visibility
    localparam logic [VIS_W-1:0] VIS_SHOWN  = 2'd0;
    localparam logic [VIS_W-1:0] VIS_HIDDEN = 2'd1;
    localparam logic [VIS_W-1:0] VIS_BLINK  = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD  = 2'd2;

    typedef struct packed {
        logic              we;
        logic [MODE_W-1:0] op;
        logic [SEL_W-1:0]  sel;
        logic [DATA_W-1:0] pattern;
        logic [DATA_W-1:0] period;
    } t_digit_wr;

    typedef struct packed {
        logic [DATA_W-1:0] pattern;
        logic [VIS_W-1:0]  vis;
        logic [DATA_W-1:0] period;
    } t_digit_rd;

    typedef struct packed {
        logic busy;
        logic done;
        logic odd;   // quotient bit 0
    } t_div_stat;

endpackage

`default_nettype wire

@@ src/sdsb_divider.sv @@
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module sdsb_divider
    import sdsb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DATA_W-1:0] i_dividend,
    input  wire logic [DATA_W-1:0] i_divisor,
    output t_div_stat              o_stat
);

    localparam int STEP_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dvs;

    logic [DATA_W:0]   w_trial;
    logic [DATA_W:0]   w_diff;

    assign w_trial = {r_rem, r_quo[DATA_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                if (!w_diff[DATA_W]) begin
                    r_rem <= w_diff[DATA_W-1:0];
                end else begin
                    r_rem <= w_trial[DATA_W-1:0];
                end
                r_quo  <= {r_quo[DATA_W-2:0], ~w_diff[DATA_W]};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.odd  = r_quo[0];

endmodule

`default_nettype wire

@@ src/sdsb_digit_store.sv @@
`default_nettype none

// Per-digit pattern, visibility and blink period; registered read.
module sdsb_digit_store
    import sdsb_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_digit_wr              i_wr,
    input  wire logic [CNT_W-1:0]       i_digit_count,
    input  wire logic [((MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1)-1:0] i_rd_addr,
    output t_digit_rd                   o_rd
);

    localparam int CMP_W = ((SEL_W > $clog2(MAX_DIGITS + 1)) ? SEL_W
                                                             : $clog2(MAX_DIGITS + 1)) + 1;

    logic [DATA_W-1:0] r_pattern [MAX_DIGITS];
    logic [VIS_W-1:0]  r_vis     [MAX_DIGITS];
    logic [DATA_W-1:0] r_period  [MAX_DIGITS];
    logic [MAX_DIGITS-1:0] w_en;
    logic              w_ok;

    // blink with a zero period is dropped
    assign w_ok = i_wr.we && !((i_wr.op == OP_BLINK) && (i_wr.period == '0));

    always_comb begin
        for (int k = 0; k < MAX_DIGITS; k++) begin
            if (i_wr.sel == '0) begin
                w_en[k] = w_ok && (CMP_W'(i_digit_count) > CMP_W'(k));
            end else begin
                w_en[k] = w_ok && (CMP_W'(i_wr.sel) == CMP_W'(k + 1))
                               && (CMP_W'(i_wr.sel) <= CMP_W'(i_digit_count));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_DIGITS; k++) begin
                r_pattern[k] <= '0;
                r_vis[k]     <= VIS_SHOWN;
                r_period[k]  <= '0;
            end
        end else begin
            for (int k = 0; k < MAX_DIGITS; k++) begin
                if (w_en[k]) begin
                    case (i_wr.op)
                        OP_PATTERN: r_pattern[k] <= i_wr.pattern;
                        OP_HIDE:    r_vis[k]     <= VIS_HIDDEN;
                        OP_SHOW:    r_vis[k]     <= VIS_SHOWN;
                        OP_BLINK: begin
                            r_vis[k]    <= VIS_BLINK;
                            r_period[k] <= i_wr.period;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd.pattern <= r_pattern[i_rd_addr];
        o_rd.vis     <= r_vis[i_rd_addr];
        o_rd.period  <= r_period[i_rd_addr];
    end

endmodule

`default_nettype wire

@@ src/segment_display_scan_blink_unit.sv @@
// Channel   Handshake                    Payload
// -------   ---------------------------  ------------------------------------------------
// input     i_in_valid / o_in_ready      i_mode i_elapsed i_digit_sel i_segments_in
//                                        i_blink_period
// output    o_out_valid / i_out_ready    o_position o_segments_out o_last
// config    i_cfg_we (no wait)           i_cfg_index i_cfg_data
//
// Write items (pattern, hide, show, blink) and unused codes complete without leaving idle.
// A tick updates the time, runs a scan check in dynamic mode, then for each emitted
// digit a store read, the shared divider for a blinking digit, and an output beat.
// The serial divider computes time / blink period, one bit a cycle.
// Synchronous active-low reset clears control, config and digit store state with no
// sweep; the output beat payload and the divider datapath are not reset.
// A held output beat stalls the sequencer; the input side is not ready until
// the last beat of a tick is taken.
`default_nettype none
`include "segment_display_scan_blink_unit_macros.svh"

module segment_display_scan_blink_unit
    import sdsb_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // item input
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [MODE_W-1:0]    i_mode,
    input  wire logic [DATA_W-1:0]    i_elapsed,
    input  wire logic [SEL_W-1:0]     i_digit_sel,
    input  wire logic [DATA_W-1:0]    i_segments_in,
    input  wire logic [DATA_W-1:0]    i_blink_period,
    // digit drive output
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [POS_W-1:0]          o_position,
    output logic [DATA_W-1:0]         o_segments_out,
    output logic                      o_last,
    // config writes
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DATA_W-1:0]    i_cfg_data
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [CNT_W-1:0] COUNT_RESET =
        CNT_W'((MAX_DIGITS < COUNT_RESET_DEF) ? MAX_DIGITS : COUNT_RESET_DEF);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;  // dynamic mode: is a scan due
    localparam logic [2:0] ST_LOAD   = 3'd2;  // store read in flight
    localparam logic [2:0] ST_DECIDE = 3'd3;  // visibility check, start divide
    localparam logic [2:0] ST_DIV    = 3'd4;  // wait on divider
    localparam logic [2:0] ST_OUT    = 3'd5;  // beat held on output

    logic [2:0]        r_state;
    // config
    logic              r_display_mode;
    logic [CNT_W-1:0]  r_count;
    logic [DATA_W-1:0] r_scan_period;
    // time and scan state
    logic [DATA_W-1:0] r_time;
    logic [DATA_W-1:0] r_last_scan;
    logic [CNT_W-1:0]  r_scan_pos;
    logic [CNT_W-1:0]  r_cnt;        // digit being emitted
    // output beat
    logic              r_out_valid;
    logic [POS_W-1:0]  r_out_pos;
    logic [DATA_W-1:0] r_out_seg;
    logic              r_out_last;
    logic              r_div_start;

    logic              w_in_acc;
    t_digit_wr         w_wr;
    t_digit_rd         w_rd;
    t_div_stat         w_div;
    logic [DATA_W-1:0] w_since;
    logic [CNT_W-1:0]  w_scan_p;
    logic [CNT_W:0]    w_scan_inc;
    logic [CNT_W-1:0]  n_scan_pos;
    logic [CNT_W:0]    w_cnt_inc;
    logic              w_count_ok;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_wr.we      = w_in_acc && ((i_mode == OP_PATTERN) || (i_mode == OP_HIDE) ||
                                       (i_mode == OP_SHOW) || (i_mode == OP_BLINK));
    assign w_wr.op      = i_mode;
    assign w_wr.sel     = i_digit_sel;
    assign w_wr.pattern = i_segments_in;
    assign w_wr.period  = i_blink_period;

    // scan bookkeeping; a stale position past the count falls back to digit 0
    assign w_since    = r_time - r_last_scan;
    assign w_scan_p   = (r_scan_pos < r_count) ? r_scan_pos : '0;
    assign w_scan_inc = {1'b0, w_scan_p} + (CNT_W + 1)'(1);
    assign n_scan_pos = (w_scan_inc == {1'b0, r_count}) ? '0 : w_scan_inc[CNT_W-1:0];

    assign w_cnt_inc  = {1'b0, r_cnt} + (CNT_W + 1)'(1);

    assign w_count_ok = (i_cfg_data[CNT_W-1:0] != '0) &&
                        (32'(i_cfg_data[CNT_W-1:0]) <= 32'(MAX_DIGITS));

    sdsb_digit_store #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (w_wr),
        .i_digit_count (r_count),
        .i_rd_addr     (IDX_W'(r_cnt)),
        .o_rd          (w_rd)
    );

    // shared divider: time / blink period, only bit 0 of the quotient is used
    sdsb_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_time),
        .i_divisor  (w_rd.period),
        .o_stat     (w_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_display_mode <= 1'b0;
            r_count        <= COUNT_RESET;
            r_scan_period  <= SCAN_PERIOD_RESET;
            r_time         <= '0;
            r_last_scan    <= '0;
            r_scan_pos     <= '0;
            r_cnt          <= '0;
            r_out_valid    <= 1'b0;
            r_div_start    <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && (i_mode == OP_TICK)) begin
                        r_time  <= r_time + i_elapsed;
                        r_cnt   <= '0;
                        r_state <= r_display_mode ? ST_SCAN : ST_LOAD;
                    end
                end
                ST_SCAN: begin
                    if (w_since < r_scan_period) begin
                        r_state <= ST_IDLE;
                    end else begin
                        // one scan per tick, even if several periods went by
                        r_last_scan <= r_last_scan + r_scan_period;
                        r_cnt       <= w_scan_p;
                        r_scan_pos  <= n_scan_pos;
                        r_state     <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_state <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    r_out_pos  <= r_cnt[POS_W-1:0];
                    r_out_last <= r_display_mode || (w_cnt_inc == {1'b0, r_count});
                    if (w_rd.vis == VIS_HIDDEN) begin
                        r_out_seg   <= '0;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_OUT;
                    end else if ((w_rd.vis == VIS_BLINK) && (w_rd.period != '0)) begin
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIV;
                    end else begin
                        r_out_seg   <= w_rd.pattern;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_OUT;
                    end
                end
                ST_DIV: begin
                    if (w_div.done) begin
                        // odd blink phase blanks the digit
                        r_out_seg   <= w_div.odd ? '0 : w_rd.pattern;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_cnt   <= w_cnt_inc[CNT_W-1:0];
                            r_state <= ST_LOAD;
                        end
                    end
                end
                default: begin
                    r_state     <= ST_IDLE;
                    r_out_valid <= 1'b0;
                end
            endcase

            // config writes must land while idle; the user is bound to this, the block does not enforce it
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DISPLAY_MODE: begin
                        r_display_mode <= i_cfg_data[0];
                        if (i_cfg_data[0]) begin
                            r_scan_pos  <= '0;
                            r_last_scan <= r_time;
                        end
                    end
                    CFG_DIGIT_COUNT: begin
                        if (w_count_ok) begin
                            r_count <= i_cfg_data[CNT_W-1:0];
                        end
                    end
                    CFG_SCAN_PERIOD: begin
                        if (i_cfg_data != '0) begin
                            r_scan_period <= i_cfg_data;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_position     = r_out_pos;
    assign o_segments_out = r_out_seg;
    assign o_last         = r_out_last;

    // the divider start is registered, so the divider takes it while the wait state already holds
    `SDSB_ASSERT_IMP(a_ready_excl, i_clk, i_rst_n, o_out_valid, !o_in_ready,
                     "ready while beat held")
    `SDSB_ASSERT_NXT(a_write_one_cycle, i_clk, i_rst_n, w_in_acc && (i_mode != OP_TICK),
                     o_in_ready, "non-tick item not done in one cycle")
    `SDSB_ASSERT_IMP(a_div_idle, i_clk, i_rst_n, o_in_ready, !w_div.busy,
                     "divider busy while idle")
    `SDSB_ASSERT_IMP(a_div_wait, i_clk, i_rst_n, (r_state == ST_DIV) && !r_div_start,
                     w_div.busy || w_div.done, "waiting on idle divider")

endmodule

`default_nettype wire

@@ sim/tb_segment_display_scan_blink_unit.sv @@
`timescale 1ns / 100ps

module tb_segment_display_scan_blink_unit;
    import sdsb_pkg::*;

    // Mode codes the block must ignore
    localparam logic [MODE_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [MODE_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [MODE_W-1:0] OP_SPARE_C = 3'd7;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 11;
    // Drain margin, sized above the worst tick
    localparam int DRAIN_CYCLES = 320;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_REPORTS  = 10;
    localparam int IDLE_PCT     = 17;
    localparam int PHASE_ITEMS  = 22;
    localparam int NUM_PHASES   = 9;
    localparam int DIR_ROWS     = 24;
    localparam int NUM_WRITES   = 19;

    typedef struct packed {
        logic [MODE_W-1:0] op;
        logic [DATA_W-1:0] elapsed;
        logic [SEL_W-1:0]  sel;
        logic [DATA_W-1:0] segments;
        logic [DATA_W-1:0] period;
    } t_disp_item;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] seg;
        logic              last;
    } t_scan_beat;

    // Directed row: typed = 1 means the beats are spelled out here
    // (n_beats beats, positions from 0, all carrying beat_seg)
    typedef struct packed {
        t_disp_item        item;
        logic              typed;
        logic [3:0]        n_beats;
        logic [DATA_W-1:0] beat_seg;
    } t_dir_row;

    typedef struct packed {
        logic [3:0]           phase;
        logic [CFG_IDX_W-1:0] idx;
        logic [DATA_W-1:0]    data;
    } t_cfg_step;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 in_valid    = 1'b0;
    logic [MODE_W-1:0]    in_mode     = OP_TICK;
    logic [DATA_W-1:0]    in_elapsed  = '0;
    logic [SEL_W-1:0]     in_sel      = '0;
    logic [DATA_W-1:0]    in_segments = '0;
    logic [DATA_W-1:0]    in_period   = '0;
    logic                 out_ready   = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = CFG_DISPLAY_MODE;
    logic [DATA_W-1:0]    cfg_data    = '0;

    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [POS_W-1:0]     o_position;
    logic [DATA_W-1:0]    o_segments_out;
    logic                 o_last;

    segment_display_scan_blink_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (in_mode),
        .i_elapsed      (in_elapsed),
        .i_digit_sel    (in_sel),
        .i_segments_in  (in_segments),
        .i_blink_period (in_period),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_position     (o_position),
        .o_segments_out (o_segments_out),
        .o_last         (o_last),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // Display state mirror
    // ------------------------------------------------------------------
    logic              dyn_mode;
    int                n_digits;
    logic [DATA_W-1:0] scan_interval;
    logic [DATA_W-1:0] time_units;
    logic [DATA_W-1:0] last_scan_at;
    int                scan_slot;
    logic [DATA_W-1:0] disp_pattern [MAX_DIGITS_DEF];
    logic [VIS_W-1:0]  disp_vis     [MAX_DIGITS_DEF];
    logic [DATA_W-1:0] disp_blink   [MAX_DIGITS_DEF];

    t_scan_beat step_beats[$];      // beats caused by the item just taken
    t_scan_beat pending_drives[$];  // beats still owed by the block
    t_scan_beat seen_beat;
    t_scan_beat owed_beat;

    int idle_pct = IDLE_PCT;
    int stall_pct = IDLE_PCT;
    int cycle_count = 0;
    int drive_errors = 0;
    int beats_seen = 0;
    int ticks_sent = 0;
    int writes_sent = 0;
    int spare_sent = 0;

    // Directed rows, run at the reset settings (static, 8 digits)
    t_dir_row dir_table [DIR_ROWS] = '{
        // blank display straight out of reset
        '{'{OP_TICK,    32'd0,         4'd0,  32'd0,         32'd0},         1'b1, 4'd8, 32'd0},
        '{'{OP_PATTERN, 32'd0,         4'd0,  32'hFFFF_FFFF, 32'd0},         1'b1, 4'd0, 32'd0},
        '{'{OP_TICK,    32'd1,         4'd0,  32'd0,         32'd0},
          1'b1, 4'd8, 32'hFFFF_FFFF},
        '{'{OP_HIDE,    32'd0,         4'd0,  32'd0,         32'd0},         1'b1, 4'd0, 32'd0},
        '{'{OP_TICK,    32'd0,         4'd0,  32'd0,         32'd0},         1'b1, 4'd8, 32'd0},
        '{'{OP_SHOW,    32'd0,         4'd0,  32'd0,         32'd0},         1'b1, 4'd0, 32'd0},
        '{'{OP_PATTERN, 32'd0,         4'd1,  32'h0000_003F, 32'd0},         1'b0, 4'd0, 32'd0},
        '{'{OP_PATTERN, 32'd0,         4'd8,  32'h8000_0000, 32'd0},         1'b0, 4'd0, 32'd0},
        // digit beyond the count, then the top select code
        '{'{OP_PATTERN, 32'd0,         4'd9,  32'h1234_5678, 32'd0},         1'b1, 4'd0, 32'd0},
        '{'{OP_PATTERN, 32'd0,         4'd15, 32'hFFFF_0000, 32'd0},         1'b1, 4'd0, 32'd0},
        // spare codes with loud payloads
        '{'{OP_SPARE_A, 32'hFFFF_FFFF, 4'd0,  32'd0,         32'd1},         1'b1, 4'd0, 32'd0},
        '{'{OP_SPARE_B, 32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, 4'd0, 32'd0},
        '{'{OP_SPARE_C, 32'd7,         4'd3,  32'h5A5A_5A5A, 32'd0},         1'b1, 4'd0, 32'd0},
        // blink with period 0 must not touch anything
        '{'{OP_BLINK,   32'd0,         4'd0,  32'd0,         32'd0},         1'b1, 4'd0, 32'd0},
        '{'{OP_TICK,    32'd0,         4'd0,  32'd0,         32'd0},         1'b0, 4'd0, 32'd0},
        '{'{OP_BLINK,   32'd0,         4'd2,  32'd0,         32'd1},         1'b0, 4'd0, 32'd0},
        '{'{OP_BLINK,   32'd0,         4'd3,  32'd0,         32'hFFFF_FFFF}, 1'b0, 4'd0, 32'd0},
        '{'{OP_HIDE,    32'd0,         4'd4,  32'd0,         32'd0},         1'b0, 4'd0, 32'd0},
        // time counter wraps to zero
        '{'{OP_TICK,    32'hFFFF_FFFF, 4'd0,  32'd0,         32'd0},         1'b0, 4'd0, 32'd0},
        '{'{OP_TICK,    32'd1,         4'd0,  32'd0,         32'd0},         1'b0, 4'd0, 32'd0},
        '{'{OP_BLINK,   32'd0,         4'd0,  32'd0,         32'd2},         1'b0, 4'd0, 32'd0},
        '{'{OP_TICK,    32'd3,         4'd0,  32'd0,         32'd0},         1'b0, 4'd0, 32'd0},
        '{'{OP_SHOW,    32'd0,         4'd2,  32'd0,         32'd0},         1'b0, 4'd0, 32'd0},
        '{'{OP_TICK,    32'd0,         4'd0,  32'd0,         32'd0},         1'b0, 4'd0, 32'd0}
    };

    // Register writes per phase; bad counts and a zero scan period ride along
    t_cfg_step phase_writes [NUM_WRITES] = '{
        '{4'd0, CFG_DISPLAY_MODE, 32'd0},
        '{4'd0, CFG_DIGIT_COUNT,  32'd8},
        '{4'd0, CFG_SCAN_PERIOD,  32'd2},
        '{4'd1, CFG_DIGIT_COUNT,  32'd1},
        '{4'd1, CFG_SCAN_PERIOD,  32'd0},
        '{4'd2, CFG_DIGIT_COUNT,  32'd0},
        '{4'd2, CFG_DISPLAY_MODE, 32'd1},
        '{4'd2, CFG_SCAN_PERIOD,  32'd1},
        '{4'd3, CFG_DIGIT_COUNT,  32'd8},
        '{4'd3, CFG_SCAN_PERIOD,  32'd5},
        '{4'd3, CFG_DISPLAY_MODE, 32'd1},
        // shrink the count under a running scan: slot may sit past it
        '{4'd4, CFG_DIGIT_COUNT,  32'd3},
        '{4'd5, CFG_SCAN_PERIOD,  32'hFFFF_FFFF},
        '{4'd5, CFG_DIGIT_COUNT,  32'd1},
        '{4'd5, CFG_DIGIT_COUNT,  32'd9},
        '{4'd6, CFG_DISPLAY_MODE, 32'd0},
        '{4'd6, CFG_DIGIT_COUNT,  32'd15},
        '{4'd6, CFG_DIGIT_COUNT,  32'd5},
        '{4'd7, CFG_SCAN_PERIOD,  32'd2}
    };

    // ------------------------------------------------------------------
    // Clock and cycle watchdog
    // ------------------------------------------------------------------
    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d beats still owed",
                     cycle_count, pending_drives.size());
            $display("** segment_display_scan_blink_unit: FAILED **");
            $finish;
        end
    end

    // Sink side back-pressure, re-rolled every cycle
    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Display model
    // ------------------------------------------------------------------
    function automatic void clear_display();
        dyn_mode      = 1'b0;
        n_digits      = COUNT_RESET_DEF;
        scan_interval = SCAN_PERIOD_RESET;
        time_units    = '0;
        last_scan_at  = '0;
        scan_slot     = 0;
        for (int i = 0; i < MAX_DIGITS_DEF; i++) begin
            disp_pattern[i] = '0;
            disp_vis[i]     = VIS_SHOWN;
            disp_blink[i]   = '0;
        end
    endfunction

    // Segments a digit drives right now; blinking digits go dark on odd half-periods
    function automatic logic [DATA_W-1:0] digit_drive(int idx);
        if (disp_vis[idx] == VIS_HIDDEN)
            return '0;
        if (disp_vis[idx] == VIS_BLINK && disp_blink[idx] != '0
                && ((time_units / disp_blink[idx]) & 32'd1) != '0)
            return '0;
        return disp_pattern[idx];
    endfunction

    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [DATA_W-1:0] val);
        if (idx == CFG_DISPLAY_MODE) begin
            dyn_mode = val[0];
            // entering (or re-entering) scan mode restarts the scan here
            if (dyn_mode) begin
                scan_slot    = 0;
                last_scan_at = time_units;
            end
        end else if (idx == CFG_DIGIT_COUNT) begin
            if (val[3:0] >= 4'd1 && val[3:0] <= 4'(MAX_DIGITS_DEF))
                n_digits = int'(val[3:0]);
        end else if (idx == CFG_SCAN_PERIOD) begin
            if (val != '0)
                scan_interval = val;
        end
    endfunction

    // Update the mirror for one item and collect the beats it causes
    function automatic void compute_scan_beats(t_disp_item it);
        int lo;
        int hi;
        int p;
        t_scan_beat b;
        step_beats.delete();
        if (it.op == OP_TICK) begin
            time_units += it.elapsed;
            if (dyn_mode) begin
                // at most one digit per tick, even when several periods passed
                if (time_units - last_scan_at < scan_interval)
                    return;
                last_scan_at += scan_interval;
                p = (scan_slot < n_digits) ? scan_slot : 0;
                scan_slot = (p + 1) % n_digits;
                b.pos  = POS_W'(p);
                b.seg  = digit_drive(p);
                b.last = 1'b1;
                step_beats.push_back(b);
            end else begin
                for (int i = 0; i < n_digits; i++) begin
                    b.pos  = POS_W'(i);
                    b.seg  = digit_drive(i);
                    b.last = (i == n_digits - 1);
                    step_beats.push_back(b);
                end
            end
        end else if (it.op >= OP_PATTERN && it.op <= OP_BLINK) begin
            if (it.op == OP_BLINK && it.period == '0)
                return;
            if (it.sel == '0) begin
                lo = 0;
                hi = n_digits;
            end else if (int'(it.sel) > n_digits) begin
                return;
            end else begin
                lo = int'(it.sel) - 1;
                hi = int'(it.sel);
            end
            for (int i = lo; i < hi; i++) begin
                case (it.op)
                    OP_PATTERN: disp_pattern[i] = it.segments;
                    OP_HIDE:    disp_vis[i] = VIS_HIDDEN;
                    OP_SHOW:    disp_vis[i] = VIS_SHOWN;
                    default: begin
                        disp_vis[i]   = VIS_BLINK;
                        disp_blink[i] = it.period;
                    end
                endcase
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side: called and returns at a falling edge
    // ------------------------------------------------------------------
    task automatic send_item(input t_disp_item it, input logic typed,
                             input int n_beats, input logic [DATA_W-1:0] beat_seg);
        int gap;
        t_scan_beat b;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid    <= 1'b1;
        in_mode     <= it.op;
        in_elapsed  <= it.elapsed;
        in_sel      <= it.sel;
        in_segments <= it.segments;
        in_period   <= it.period;
        do @(posedge i_clk); while (!o_in_ready);
        // item taken at this edge
        compute_scan_beats(it);
        if (typed) begin
            step_beats.delete();
            for (int i = 0; i < n_beats; i++) begin
                b.pos  = POS_W'(i);
                b.seg  = beat_seg;
                b.last = (i == n_beats - 1);
                step_beats.push_back(b);
            end
        end
        foreach (step_beats[i]) pending_drives.push_back(step_beats[i]);
        if (it.op == OP_TICK)
            ticks_sent++;
        else if (it.op <= OP_BLINK)
            writes_sent++;
        else
            spare_sent++;
        @(negedge i_clk);
    endtask

    // Let the block finish whatever it holds before touching registers
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pending_drives.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        apply_reg_write(idx, val);
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Output side: compare each taken beat with the oldest owed one
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            beats_seen++;
            seen_beat.pos  = o_position;
            seen_beat.seg  = o_segments_out;
            seen_beat.last = o_last;
            if (pending_drives.size() == 0) begin
                drive_errors++;
                if (drive_errors <= MAX_REPORTS)
                    $display("[%0t] stray beat: pos=%0d seg=%h last=%b", $realtime,
                             seen_beat.pos, seen_beat.seg, seen_beat.last);
            end else begin
                owed_beat = pending_drives.pop_front();
                if (seen_beat.pos !== owed_beat.pos || seen_beat.seg !== owed_beat.seg
                        || seen_beat.last !== owed_beat.last) begin
                    drive_errors++;
                    if (drive_errors <= MAX_REPORTS)
                        $display("[%0t] exp pos=%0d seg=%h last=%b, got pos=%0d seg=%h last=%b",
                                 $realtime, owed_beat.pos, owed_beat.seg, owed_beat.last,
                                 seen_beat.pos, seen_beat.seg, seen_beat.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_disp_item it;
        int useful;
        int r;
        clear_display();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table at reset settings
        for (int k = 0; k < DIR_ROWS; k++)
            send_item(dir_table[k].item, dir_table[k].typed,
                      int'(dir_table[k].n_beats), dir_table[k].beat_seg);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_quiet();
            foreach (phase_writes[w])
                if (int'(phase_writes[w].phase) == ph)
                    write_reg(phase_writes[w].idx, phase_writes[w].data);
            cfg_we <= 1'b0;
            // first phase: full 8-digit static scan with no gaps on either side
            idle_pct  = (ph == 0) ? 0 : IDLE_PCT;
            stall_pct = (ph == 0) ? 0 : IDLE_PCT;

            useful = 0;
            while (useful < PHASE_ITEMS) begin
                r = $urandom_range(99);
                if (r < 40)      it.op = OP_TICK;
                else if (r < 58) it.op = OP_PATTERN;
                else if (r < 66) it.op = OP_HIDE;
                else if (r < 76) it.op = OP_SHOW;
                else if (r < 93) it.op = OP_BLINK;
                else             it.op = MODE_W'($urandom_range(5, 7));

                // elapsed: small steps, near one scan period, or anything
                case ($urandom_range(9))
                    0, 1, 2, 3: it.elapsed = DATA_W'($urandom_range(0, 4));
                    4, 5, 6:    it.elapsed = scan_interval + DATA_W'($urandom_range(0, 2))
                                             - 32'd1;
                    7:          it.elapsed = $urandom;
                    8:          it.elapsed = 32'hFFFF_FFFF;
                    default:    it.elapsed = '0;
                endcase

                it.sel = ($urandom_range(99) < 80) ? SEL_W'($urandom_range(0, n_digits))
                                                   : SEL_W'($urandom_range(0, 15));
                it.segments = $urandom;

                case ($urandom_range(9))
                    0:          it.period = '0;
                    1, 2, 3, 4: it.period = DATA_W'($urandom_range(1, 8));
                    5, 6:       it.period = DATA_W'($urandom_range(1, 64));
                    7, 8:       it.period = $urandom;
                    default:    it.period = 32'hFFFF_FFFF;
                endcase

                send_item(it, 1'b0, 0, '0);
                if (it.op <= OP_BLINK)
                    useful++;
            end
        end

        in_valid <= 1'b0;
        while (pending_drives.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Checked %0d drive beats from %0d ticks, %0d digit writes, %0d spare codes,",
                 beats_seen, ticks_sent, writes_sent, spare_sent);
        $display("over the reset setup plus %0d register settings (static and scanned); %0d bad.",
                 NUM_PHASES, drive_errors);
        if (drive_errors == 0 && pending_drives.size() == 0) begin
            $display("** segment_display_scan_blink_unit: PASSED **");
        end else begin
            $display("** segment_display_scan_blink_unit: FAILED **");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/sdsb_pkg.sv
src/sdsb_divider.sv
src/sdsb_digit_store.sv
src/segment_display_scan_blink_unit.sv
sim/tb_segment_display_scan_blink_unit.sv
